FILE: rtl/tcw_pkg.sv
// Package for the text console writer: request/result structs, cell layout,
// request codes, character constants and controller states. No dependencies.
`default_nettype none

package tcw_pkg;

  // Request codes
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_MOVE  = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam logic [7:0] NL_CODE      = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] RESET_ATTRIB = 8'd7;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [7:0] char_attrib;
    logic       last_of_text;
    logic [6:0] col;
    logic [4:0] row;
  } req_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] read_char;
    logic [7:0] read_attrib;
  } result_t;

  // One character cell: attribute in the high byte, character in the low byte
  typedef struct packed {
    logic [7:0] attrib;
    logic [7:0] code;
  } cell_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REPLY,
    ST_SCROLL,
    ST_DRAIN,
    ST_FILL
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/tcw_cell_ram.sv
// Character cell store: one write port, one read port, registered read data.
// Depends on tcw_pkg for the cell type.
`default_nettype none

module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire tcw_pkg::cell_t  wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output tcw_pkg::cell_t       rdata
);
  import tcw_pkg::*;

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/text_console_writer_unit.sv
// Text console writer top level: cursor control, scroll/clear sequencer and
// the cell store. Depends on tcw_pkg and tcw_cell_ram.
`default_nettype none
//
// Usage
//   Requests: drive req and raise start; a request is taken on a rising edge
//   with start high and busy low. One request is in work at a time.
//   Results: done is high for one cycle with result valid; the receiver
//   cannot stall, so the result is taken in that cycle. The cursor fields
//   carry the visible cursor after the request; read fields are zero except
//   for a read.
//   Config: cfg_data is written into fill_attrib whenever cfg_valid is high
//   (cfg_ready is always high). Write it only while no request is in work.
// From request accept to done (the cell store's read data is registered):
//   put without scroll, move, read: the reply state, then done.
//   clear: COLS*ROWS cell writes (one cell written per cycle), then reply.
//   put that scrolls: COLS*(ROWS-1) copy reads, one drain write, COLS blank
//   writes, then reply.
// Reset: a clearing pass over all COLS*ROWS cells fills the store with
// spaces in attribute 7; busy stays high through it. Config writes are taken
// meanwhile and do not affect that pass.
//
module text_console_writer_unit #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire tcw_pkg::req_t  req,
  output logic                done,
  output tcw_pkg::result_t    result,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [7:0]     cfg_data
);
  import tcw_pkg::*;

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = $clog2(CELLS + 1);  // sweep counter reaches CELLS
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);

  state_t        state, state_next;
  logic [SW-1:0] scan, scan_next;        // sweep position for scroll / fill
  logic [CW-1:0] run_col, run_col_next;
  logic [RW-1:0] run_row, run_row_next;
  logic [CW-1:0] shown_col, shown_col_next;
  logic [RW-1:0] shown_row, shown_row_next;
  logic [7:0]    fill_attrib;
  logic [7:0]    blank_attr, blank_attr_next;  // attribute latched for a fill
  logic          fill_reply, fill_reply_next;  // fill ends in a reply
  logic          rd_req, rd_req_next;
  logic          done_next;
  result_t       result_next;

  // Cell store ports
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  cell_t         wdata, rdata;

  // Clamped request position and linear addresses
  logic [CW-1:0] pos_col;
  logic [RW-1:0] pos_row;
  logic [AW-1:0] pos_addr, put_addr;

  // Put-character cursor advance
  logic          adv, wrap_scroll;
  logic [CW-1:0] put_col;
  logic [RW-1:0] put_row;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);

  assign pos_col = ({1'b0, req.col} >= 8'(COLS)) ? CW'(COLS - 1) : CW'(req.col);
  assign pos_row = ({2'b0, req.row} >= 7'(ROWS)) ? RW'(ROWS - 1) : RW'(req.row);
  assign pos_addr = AW'(pos_row * COLS) + AW'(pos_col);
  assign put_addr = AW'(run_row * COLS) + AW'(run_col);

  // Newline or last column moves to column 0 of the next row; past the
  // bottom row the screen scrolls and the row stays on the bottom row.
  assign adv         = (req.char_code == NL_CODE) || (run_col == CW'(COLS - 1));
  assign wrap_scroll = adv && (run_row == RW'(ROWS - 1));
  assign put_col     = adv ? '0 : CW'(run_col + 1'b1);
  assign put_row     = (adv && !wrap_scroll) ? RW'(run_row + 1'b1) : run_row;

  tcw_cell_ram #(
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_FILL;   // clearing pass after reset
      scan        <= '0;
      blank_attr  <= RESET_ATTRIB;
      fill_reply  <= 1'b0;
      rd_req      <= 1'b0;
      run_col     <= '0;
      run_row     <= '0;
      shown_col   <= '0;
      shown_row   <= '0;
      fill_attrib <= RESET_ATTRIB;
      done        <= 1'b0;
    end else begin
      state      <= state_next;
      scan       <= scan_next;
      blank_attr <= blank_attr_next;
      fill_reply <= fill_reply_next;
      rd_req     <= rd_req_next;
      run_col    <= run_col_next;
      run_row    <= run_row_next;
      shown_col  <= shown_col_next;
      shown_row  <= shown_row_next;
      done       <= done_next;
      if (cfg_valid && cfg_ready) begin
        fill_attrib <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  always_comb begin
    state_next      = state;
    scan_next       = scan;
    blank_attr_next = blank_attr;
    fill_reply_next = fill_reply;
    rd_req_next     = rd_req;
    run_col_next    = run_col;
    run_row_next    = run_row;
    shown_col_next  = shown_col;
    shown_row_next  = shown_row;
    done_next       = 1'b0;
    result_next     = result;
    we              = 1'b0;
    waddr           = '0;
    wdata           = '{attrib: blank_attr, code: SPACE_CODE};
    re              = 1'b0;
    raddr           = '0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          rd_req_next = 1'b0;
          case (req.req_type)
            REQ_PUT: begin
              if (req.char_code != NL_CODE) begin
                we    = 1'b1;
                waddr = put_addr;
                wdata = '{attrib: req.char_attrib, code: req.char_code};
              end
              run_col_next = put_col;
              run_row_next = put_row;
              if (req.last_of_text) begin
                shown_col_next = put_col;
                shown_row_next = put_row;
              end
              scan_next  = SW'(COLS);
              state_next = wrap_scroll ? ST_SCROLL : ST_REPLY;
            end
            REQ_CLEAR: begin
              run_col_next    = '0;
              run_row_next    = '0;
              shown_col_next  = '0;
              shown_row_next  = '0;
              scan_next       = '0;
              blank_attr_next = fill_attrib;
              fill_reply_next = 1'b1;
              state_next      = ST_FILL;
            end
            REQ_MOVE: begin
              run_col_next   = pos_col;
              run_row_next   = pos_row;
              shown_col_next = pos_col;
              shown_row_next = pos_row;
              state_next     = ST_REPLY;
            end
            default: begin  // read cell
              re          = 1'b1;
              raddr       = pos_addr;
              rd_req_next = 1'b1;
              state_next  = ST_REPLY;
            end
          endcase
        end
      end

      ST_REPLY: begin
        done_next              = 1'b1;
        result_next.cursor_col = 7'(shown_col);
        result_next.cursor_row = 5'(shown_row);
        result_next.read_char  = rd_req ? rdata.code   : 8'd0;
        result_next.read_attrib = rd_req ? rdata.attrib : 8'd0;
        state_next             = ST_IDLE;
      end

      ST_SCROLL: begin
        // read source cell, write back the previously read cell one row up
        re    = 1'b1;
        raddr = scan[AW-1:0];
        if (scan != SW'(COLS)) begin
          we    = 1'b1;
          waddr = AW'(scan - SW'(COLS + 1));
          wdata = rdata;
        end
        scan_next = SW'(scan + 1'b1);
        if (scan == SW'(CELLS - 1)) begin
          state_next = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        we              = 1'b1;
        waddr           = AW'(scan - SW'(COLS + 1));
        wdata           = rdata;
        scan_next       = SW'((ROWS - 1) * COLS);
        blank_attr_next = fill_attrib;
        fill_reply_next = 1'b1;
        state_next      = ST_FILL;
      end

      ST_FILL: begin
        we        = 1'b1;
        waddr     = scan[AW-1:0];
        scan_next = SW'(scan + 1'b1);
        if (scan == SW'(CELLS - 1)) begin
          state_next = fill_reply ? ST_REPLY : ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/tcw_checker.sv
// Port-level checks for text_console_writer_unit, bound to the top level.
// Depends only on the top level's port names.
`default_nettype none

module tcw_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  // reset starts the clearing pass: busy, no result
  a_reset_busy: assert property (@(posedge clk) rst |=> (busy && !done))
    else $error("reset did not enter clearing pass");

  // a result is only shown with the block back at idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // an accepted request occupies the block and cannot reply at once
  a_accept: assert property (@(posedge clk) disable iff (rst)
      (start && !busy) |=> (busy && !done))
    else $error("request accept not followed by busy");

  // one request, one strobe
  a_single_done: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

bind text_console_writer_unit tcw_checker u_tcw_checker (.*);

`default_nettype wire
